>>> src/rcs_pkg.sv
// Shared types, datapath action codes, jump conditions and the microprogram
// for the resource count selector. No dependencies.
`default_nettype none
package rcs_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int FIELD_WIDTH = 32;
  localparam int OPERAND_WIDTH = 31;
  localparam int MODE_WIDTH = 2;
  localparam int PC_WIDTH = 5;

  localparam logic [MODE_WIDTH-1:0] MODE_ADD = 2'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_MUL = 2'd1;
  localparam logic [MODE_WIDTH-1:0] MODE_POW = 2'd2;

  typedef logic [3:0] act_t;
  typedef logic [3:0] cond_t;
  typedef logic [PC_WIDTH-1:0] pc_t;

  localparam act_t ACT_NONE          = 4'd0;
  localparam act_t ACT_CLEAR         = 4'd1;
  localparam act_t ACT_ADD_INIT      = 4'd2;
  localparam act_t ACT_MOD_STEP      = 4'd3;
  localparam act_t ACT_ADD_FIX       = 4'd4;
  localparam act_t ACT_LOAD_CUR      = 4'd5;
  localparam act_t ACT_TAKE          = 4'd6;
  localparam act_t ACT_MUL_INIT_OP   = 4'd7;
  localparam act_t ACT_MUL_STEP      = 4'd8;
  localparam act_t ACT_MUL_STORE     = 4'd9;
  localparam act_t ACT_POW_TAKE      = 4'd10;
  localparam act_t ACT_MUL_INIT_BASE = 4'd11;
  localparam act_t ACT_POW_STORE     = 4'd12;
  localparam act_t ACT_DONE          = 4'd13;

  localparam cond_t C_NEVER       = 4'd0;
  localparam cond_t C_ALWAYS      = 4'd1;
  localparam cond_t C_BAD_RANGE   = 4'd2;
  localparam cond_t C_MODE_ADD    = 4'd3;
  localparam cond_t C_MODE_MUL    = 4'd4;
  localparam cond_t C_MODE_POW    = 4'd5;
  localparam cond_t C_OP_ZERO     = 4'd6;
  localparam cond_t C_OP_ONE      = 4'd7;
  localparam cond_t C_POW_TRIVIAL = 4'd8;
  localparam cond_t C_OUT_RANGE   = 4'd9;
  localparam cond_t C_CUR_ZERO    = 4'd10;
  localparam cond_t C_MORE        = 4'd11;
  localparam cond_t C_MUL_END     = 4'd12;
  localparam cond_t C_OVF         = 4'd13;
  localparam cond_t C_I_DONE      = 4'd14;

  localparam pc_t PC_ADD  = 5'd5;
  localparam pc_t PC_MOD  = 5'd6;
  localparam pc_t PC_MUL  = 5'd8;
  localparam pc_t PC_MHEAD = 5'd9;
  localparam pc_t PC_MSTEP = 5'd12;
  localparam pc_t PC_TAKE = 5'd15;
  localparam pc_t PC_POW  = 5'd16;
  localparam pc_t PC_PHEAD = 5'd17;
  localparam pc_t PC_PINNER = 5'd19;
  localparam pc_t PC_PSTEP = 5'd21;
  localparam pc_t PC_FIN  = 5'd24;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    pc_t   target;
  } uword_t;

  function automatic uword_t ucode_rom(input pc_t pc);
    uword_t w;
    w = '{act: ACT_NONE, cond: C_NEVER, target: PC_FIN};
    case (pc)
      5'd0:  w = '{act: ACT_CLEAR,         cond: C_BAD_RANGE,   target: PC_FIN};
      5'd1:  w = '{act: ACT_NONE,          cond: C_MODE_ADD,    target: PC_ADD};
      5'd2:  w = '{act: ACT_NONE,          cond: C_MODE_MUL,    target: PC_MUL};
      5'd3:  w = '{act: ACT_NONE,          cond: C_MODE_POW,    target: PC_POW};
      5'd4:  w = '{act: ACT_NONE,          cond: C_ALWAYS,      target: PC_FIN};
      5'd5:  w = '{act: ACT_ADD_INIT,      cond: C_OP_ZERO,     target: PC_FIN};
      5'd6:  w = '{act: ACT_MOD_STEP,      cond: C_MORE,        target: PC_MOD};
      5'd7:  w = '{act: ACT_ADD_FIX,       cond: C_ALWAYS,      target: PC_FIN};
      5'd8:  w = '{act: ACT_LOAD_CUR,      cond: C_OP_ONE,      target: PC_TAKE};
      5'd9:  w = '{act: ACT_NONE,          cond: C_OUT_RANGE,   target: PC_FIN};
      5'd10: w = '{act: ACT_TAKE,          cond: C_CUR_ZERO,    target: PC_FIN};
      5'd11: w = '{act: ACT_MUL_INIT_OP,   cond: C_NEVER,       target: PC_FIN};
      5'd12: w = '{act: ACT_MUL_STEP,      cond: C_MORE,        target: PC_MSTEP};
      5'd13: w = '{act: ACT_MUL_STORE,     cond: C_MUL_END,     target: PC_FIN};
      5'd14: w = '{act: ACT_NONE,          cond: C_ALWAYS,      target: PC_MHEAD};
      5'd15: w = '{act: ACT_TAKE,          cond: C_ALWAYS,      target: PC_FIN};
      5'd16: w = '{act: ACT_LOAD_CUR,      cond: C_POW_TRIVIAL, target: PC_TAKE};
      5'd17: w = '{act: ACT_NONE,          cond: C_OUT_RANGE,   target: PC_FIN};
      5'd18: w = '{act: ACT_POW_TAKE,      cond: C_CUR_ZERO,    target: PC_FIN};
      5'd19: w = '{act: ACT_NONE,          cond: C_I_DONE,      target: PC_PHEAD};
      5'd20: w = '{act: ACT_MUL_INIT_BASE, cond: C_NEVER,       target: PC_FIN};
      5'd21: w = '{act: ACT_MUL_STEP,      cond: C_MORE,        target: PC_PSTEP};
      5'd22: w = '{act: ACT_POW_STORE,     cond: C_OVF,         target: PC_FIN};
      5'd23: w = '{act: ACT_NONE,          cond: C_ALWAYS,      target: PC_PINNER};
      5'd24: w = '{act: ACT_DONE,          cond: C_NEVER,       target: PC_FIN};
      default: w = '{act: ACT_DONE,        cond: C_NEVER,       target: PC_FIN};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

>>> src/rcs_sequencer.sv
// Step counter and microprogram lookup for the resource count selector.
// Depends on rcs_pkg for the control word type and the program table.
`default_nettype none
module rcs_sequencer (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire logic           jump,
  output logic                busy,
  output rcs_pkg::uword_t     uword
);
  import rcs_pkg::*;

  pc_t pc;
  pc_t pc_next;

  assign uword = ucode_rom(pc);

  always_comb begin
    pc_next = pc;
    if (accept) begin
      pc_next = '0;
    end else if (busy) begin
      pc_next = jump ? uword.target : pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_FIN;
      busy <= 1'b0;
    end else begin
      pc <= pc_next;
      if (accept) begin
        busy <= 1'b1;
      end else if (busy && uword.act == ACT_DONE) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> src/resource_count_selector.sv
// Top level of the resource count selector: operand registers, shared
// bit-serial multiplier and remainder datapath under microprogram control.
// Depends on rcs_pkg and rcs_sequencer.
//
//  Channel   Handshake          Word
//  request   start / busy       mode, count_min, count_max, step_operand, available
//  result    done (one cycle)   count
//
// A request takes a handful of control steps plus the serial units: the
// remainder walks one bit of the count per cycle, and each multiply walks
// one multiplier bit per cycle. A walk does at most COUNT_WIDTH multiplies.
// Reset returns the sequencer to idle. The receiver cannot stall; done is
// high for one cycle and busy falls in the next.
`default_nettype none
module resource_count_selector #(
  parameter int COUNT_WIDTH = rcs_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  mode,
  input  wire logic [31:0] count_min,
  input  wire logic [31:0] count_max,
  input  wire logic [30:0] step_operand,
  input  wire logic [31:0] available,
  output logic             done,
  output logic [31:0]      count
);
  import rcs_pkg::*;

  localparam int W = COUNT_WIDTH;
  localparam int OPW = (W > OPERAND_WIDTH) ? W : OPERAND_WIDTH;
  localparam int KW = $clog2(OPW + 1);
  localparam int IW = $clog2(W + 2);

  logic                     accept;
  logic                     jump;
  uword_t                   uword;

  logic [MODE_WIDTH-1:0]    mode_r;
  logic [W-1:0]             cmin;
  logic [W-1:0]             cmax;
  logic [W-1:0]             avail;
  logic [OPERAND_WIDTH-1:0] op;
  logic [W-1:0]             cur;
  logic [W-1:0]             base;
  logic [W-1:0]             cnt;
  logic [W-1:0]             acc;
  logic                     ovf;
  logic [OPW-1:0]           mplier;
  logic [OPERAND_WIDTH-1:0] rem;
  logic [KW-1:0]            k;
  logic [IW-1:0]            i;

  logic [W-1:0]             lim;
  logic [W+1:0]             mul_sum;
  logic [OPERAND_WIDTH:0]   rem_sh;
  logic [OPERAND_WIDTH:0]   rem_sub;

  assign accept = start && !busy;
  assign done = busy && uword.act == ACT_DONE;
  assign count = 32'(cnt);

  rcs_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .jump   (jump),
    .busy   (busy),
    .uword  (uword)
  );

  always_comb begin
    lim = (avail < cmax) ? avail : cmax;
    mul_sum = {acc, 1'b0} + {2'b00, (mplier[OPW-1] ? cur : {W{1'b0}})};
    rem_sh = {rem, acc[W-1]};
    rem_sub = rem_sh - {1'b0, op};
  end

  always_comb begin
    case (uword.cond)
      C_NEVER:       jump = 1'b0;
      C_ALWAYS:      jump = 1'b1;
      C_BAD_RANGE:   jump = (cmin > cmax) || (cmin > avail);
      C_MODE_ADD:    jump = mode_r == MODE_ADD;
      C_MODE_MUL:    jump = mode_r == MODE_MUL;
      C_MODE_POW:    jump = mode_r == MODE_POW;
      C_OP_ZERO:     jump = op == '0;
      C_OP_ONE:      jump = op == OPERAND_WIDTH'(1);
      C_POW_TRIVIAL: jump = (op < OPERAND_WIDTH'(2)) || (cmin == W'(1));
      C_OUT_RANGE:   jump = (cur > avail) || (cur > cmax);
      C_CUR_ZERO:    jump = cur == '0;
      C_MORE:        jump = k != KW'(1);
      C_MUL_END:     jump = ovf || (acc == '0);
      C_OVF:         jump = ovf;
      C_I_DONE:      jump = OPERAND_WIDTH'(i) >= op;
      default:       jump = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= mode;
      cmin <= W'(count_min);
      cmax <= W'(count_max);
      avail <= W'(available);
      op <= step_operand;
    end else if (busy) begin
      case (uword.act)
        ACT_CLEAR: begin
          cnt <= '0;
        end
        ACT_ADD_INIT: begin
          cnt <= lim;
          acc <= lim - cmin;
          rem <= '0;
          k <= KW'(W);
        end
        ACT_MOD_STEP: begin
          rem <= (rem_sh >= {1'b0, op}) ? rem_sub[OPERAND_WIDTH-1:0]
                                        : rem_sh[OPERAND_WIDTH-1:0];
          acc <= {acc[W-2:0], 1'b0};
          k <= k - 1'b1;
        end
        ACT_ADD_FIX: begin
          cnt <= cnt - W'(rem);
        end
        ACT_LOAD_CUR: begin
          cur <= cmin;
        end
        ACT_TAKE: begin
          cnt <= cur;
        end
        ACT_MUL_INIT_OP: begin
          acc <= '0;
          ovf <= 1'b0;
          mplier <= OPW'(op);
          k <= KW'(OPW);
        end
        ACT_MUL_STEP: begin
          acc <= mul_sum[W-1:0];
          if (mul_sum[W+1:W] != 2'b00) begin
            ovf <= 1'b1;
          end
          mplier <= {mplier[OPW-2:0], 1'b0};
          k <= k - 1'b1;
        end
        ACT_MUL_STORE: begin
          cur <= acc;
        end
        ACT_POW_TAKE: begin
          cnt <= cur;
          base <= cur;
          i <= IW'(1);
          ovf <= 1'b0;
        end
        ACT_MUL_INIT_BASE: begin
          acc <= '0;
          mplier <= OPW'(base);
          k <= KW'(OPW);
        end
        ACT_POW_STORE: begin
          cur <= acc;
          i <= i + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire
